// ===== sv/fragment_reassembly_tracker_top_defines.svh =====
// Assertion macros shared by the fragment reassembly tracker RTL.
// Expects signals named clock and reset in the including module.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FRT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FRT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/frt_pkg.sv =====
// Shared types and constants for the fragment reassembly tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

   localparam int REQ_TDATA_W  = 96;
   localparam int RSP_TDATA_W  = 80;
   localparam int STATUS_W     = 3;
   localparam int SLOT_FIELD_W = 4;
   localparam int BLOCK_W      = 32;
   localparam int TOTAL_W      = 38;

   localparam logic signed [BLOCK_W-1:0] END_MARK = -32'sd1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED = 3'd0,
      STATUS_DUP    = 3'd1,
      STATUS_DONE   = 3'd2,
      STATUS_BUSY   = 3'd3,
      STATUS_RANGE  = 3'd4,
      STATUS_END    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FRT_CLEAR,
      FRT_IDLE,
      FRT_MOD,
      FRT_READ,
      FRT_EVAL
   } frt_state_type;

   typedef struct packed {
      status_type         status;
      logic               write;
      logic [TOTAL_W-1:0] byte_sum;
   } frt_verdict_type;

endpackage

`default_nettype wire

// ===== sv/frt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/frt_slot_map.sv =====
// Two-stage block index to table slot mapping (index mod SLOTS).
// Multiply by a reciprocal, then subtract quotient times SLOTS. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frt_slot_map #(
   parameter int SLOTS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire logic [30:0]              block_in,
   input  wire logic                     advance,
   output      logic [$clog2(SLOTS)-1:0] slot
);

   localparam int SW    = $clog2(SLOTS);
   localparam int SHIFT = 31 + SW;
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam logic [31:0] RECIP_LO = RECIP[31:0];

   logic [62:0] prod_ff;
   logic [30:0] blk_ff;
   logic [30:0] quot;
   logic [30:0] quot_scaled;
   logic [30:0] rem;

   // Exact quotient for every 31-bit dividend.
   assign quot        = 31'(prod_ff >> SHIFT);
   assign quot_scaled = 31'(quot * 31'(SLOTS));
   assign rem         = blk_ff - quot_scaled;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= 63'(block_in) * 63'(RECIP_LO);
         blk_ff  <= block_in;
      end
      if (advance) begin
         slot <= SW'(rem);
      end
   end

endmodule

`default_nettype wire

// ===== sv/frt_update.sv =====
// Entry evaluation: classify one fragment against its table entry, build the
// write-back word. Depends on frt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frt_update #(
   parameter int MAX_FRAGMENTS = 64
) (
   input  wire logic signed [31:0]          blk_id,
   input  wire logic [15:0]                 frag_pos,
   input  wire logic [15:0]                 frag_total,
   input  wire logic [31:0]                 payload_bytes,
   input  wire logic [1+31+MAX_FRAGMENTS+2*$clog2(MAX_FRAGMENTS+1)+38-1:0] entry_rd,
   output      logic [1+31+MAX_FRAGMENTS+2*$clog2(MAX_FRAGMENTS+1)+38-1:0] entry_wr,
   output      frt_pkg::frt_verdict_type    verdict
);

   localparam int CW = $clog2(MAX_FRAGMENTS + 1);
   localparam int TW = frt_pkg::TOTAL_W;
   localparam int EW = 1 + 31 + MAX_FRAGMENTS + 2 * CW + TW;
   localparam logic [15:0] MAX_COUNT = 16'(MAX_FRAGMENTS);
   localparam logic [MAX_FRAGMENTS-1:0] MAP_ONE = MAX_FRAGMENTS'(1);

   logic                     ent_valid;
   logic [30:0]              ent_tag;
   logic [MAX_FRAGMENTS-1:0] ent_map;
   logic [CW-1:0]            ent_cnt;
   logic [CW-1:0]            ent_exp;
   logic [TW-1:0]            ent_total;

   logic                     fresh;
   logic [MAX_FRAGMENTS-1:0] map_base;
   logic [MAX_FRAGMENTS-1:0] bit_vec;
   logic [CW-1:0]            cnt_base;
   logic [CW-1:0]            cnt_new;
   logic [CW-1:0]            exp_eff;
   logic [TW-1:0]            total_base;
   logic [TW:0]              sum;
   logic [TW-1:0]            sum_sat;
   logic                     complete;

   assign {ent_valid, ent_tag, ent_map, ent_cnt, ent_exp, ent_total} = entry_rd;

   // A free entry starts from a clean bitmap, zero count and zero total.
   assign fresh      = !ent_valid;
   assign map_base   = fresh ? '0 : ent_map;
   assign cnt_base   = fresh ? '0 : ent_cnt;
   assign total_base = fresh ? '0 : ent_total;
   assign exp_eff    = fresh ? CW'(frag_total) : ent_exp;
   assign bit_vec    = MAP_ONE << frag_pos;
   assign cnt_new    = cnt_base + CW'(1);
   assign sum        = {1'b0, total_base} + (TW + 1)'(payload_bytes);
   assign sum_sat    = sum[TW] ? frt_pkg::TOTAL_MAX : sum[TW-1:0];
   assign complete   = cnt_new >= exp_eff;

   assign entry_wr = EW'({!complete, blk_id[30:0], map_base | bit_vec,
                          cnt_new, exp_eff, sum_sat});

   always_comb begin
      verdict.status   = frt_pkg::STATUS_STORED;
      verdict.write    = 1'b0;
      verdict.byte_sum = '0;
      priority if (blk_id == frt_pkg::END_MARK) begin
         verdict.status = frt_pkg::STATUS_END;
      end else if (blk_id[31]) begin
         verdict.status = frt_pkg::STATUS_RANGE;
      end else if (ent_valid && (ent_tag != blk_id[30:0])) begin
         verdict.status = frt_pkg::STATUS_BUSY;
      end else if (fresh && ((frag_total == 16'd0) || (frag_total > MAX_COUNT)
                             || (frag_pos >= frag_total))) begin
         verdict.status = frt_pkg::STATUS_RANGE;
      end else if (!fresh && (frag_pos >= 16'(ent_exp))) begin
         verdict.status   = frt_pkg::STATUS_RANGE;
         verdict.byte_sum = ent_total;
      end else if ((map_base & bit_vec) != '0) begin
         verdict.status   = frt_pkg::STATUS_DUP;
         verdict.byte_sum = total_base;
      end else begin
         verdict.status   = complete ? frt_pkg::STATUS_DONE : frt_pkg::STATUS_STORED;
         verdict.write    = 1'b1;
         verdict.byte_sum = sum_sat;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fragment_reassembly_tracker_top.sv =====
// Fragment reassembly tracker: one status word per fragment header.
// Path: header accept to status word shown through remainder, table read,
//   evaluate and write back, one header in flight.
// Flow: a new header is taken only in idle, after the table read-modify-write;
//   a stalled status word holds the next header in evaluate.
// Reset: synchronous; afterwards a clearing pass writes every table entry,
//   with req_tready low.
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_reassembly_tracker_top_defines.svh"

module fragment_reassembly_tracker_top #(
   parameter int SLOTS         = 16,
   parameter int MAX_FRAGMENTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata, low bit up: blk_id[31:0], frag_pos[15:0],
   // frag_total[15:0], payload_bytes[31:0]
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [95:0] req_tdata,
   // rsp_tdata, low bit up: slot[3:0], done_block[31:0], byte_sum[37:0], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata,
   // rsp_tuser: status[2:0]
   output      logic [2:0]  rsp_tuser
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(MAX_FRAGMENTS + 1);
   localparam int EW = 1 + 31 + MAX_FRAGMENTS + 2 * CW + frt_pkg::TOTAL_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   frt_pkg::frt_state_type state_ff, state_in;

   logic [SW-1:0] clr_ff, clr_in;

   // Captured header word.
   logic signed [31:0] blk_ff;
   logic [15:0]        frag_ff;
   logic [15:0]        total_ff;
   logic [31:0]        size_ff;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [79:0]        rsp_tdata_ff;
   logic [2:0]         rsp_tuser_ff;

   logic               accept;
   logic               out_free;
   logic               eval_go;
   logic               in_clear;
   logic               map_advance;
   logic               ram_rd_en;
   logic               ram_wr_en;
   logic [SW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic [EW-1:0]      ram_rd_data;
   logic [EW-1:0]      entry_wr;
   logic [SW-1:0]      slot;
   logic [3:0]         slot_field;

   frt_pkg::frt_verdict_type verdict;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Slot of the block; the remainder lands while the FSM sits in FRT_MOD.
   frt_slot_map #(
      .SLOTS (SLOTS)
   ) u_slot_map (
      .clock    (clock),
      .load     (accept),
      .block_in (req_tdata[30:0]),
      .advance  (map_advance),
      .slot     (slot)
   );

   // Per-slot entry: valid, tag, bitmap, counts, byte total.
   frt_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   frt_update #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_update (
      .blk_id        (blk_ff),
      .frag_pos      (frag_ff),
      .frag_total    (total_ff),
      .payload_bytes (size_ff),
      .entry_rd      (ram_rd_data),
      .entry_wr      (entry_wr),
      .verdict       (verdict)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         frt_pkg::FRT_CLEAR: begin
            clr_in = clr_ff + SW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = frt_pkg::FRT_IDLE;
            end
         end
         frt_pkg::FRT_IDLE: begin
            if (req_tvalid) begin
               state_in = frt_pkg::FRT_MOD;
            end
         end
         frt_pkg::FRT_MOD:  state_in = frt_pkg::FRT_READ;
         frt_pkg::FRT_READ: state_in = frt_pkg::FRT_EVAL;
         frt_pkg::FRT_EVAL: begin
            // Hold the read data and header until the output register frees.
            if (out_free) begin
               state_in = frt_pkg::FRT_IDLE;
            end
         end
         default: state_in = frt_pkg::FRT_CLEAR;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_tready  = 1'b0;
      in_clear    = 1'b0;
      map_advance = 1'b0;
      ram_rd_en   = 1'b0;
      eval_go     = 1'b0;
      unique case (state_ff)
         frt_pkg::FRT_CLEAR: in_clear    = 1'b1;
         frt_pkg::FRT_IDLE:  req_tready  = 1'b1;
         frt_pkg::FRT_MOD:   map_advance = 1'b1;
         frt_pkg::FRT_READ:  ram_rd_en   = 1'b1;
         frt_pkg::FRT_EVAL:  eval_go     = out_free;
         default:            in_clear    = 1'b0;
      endcase
   end

   // Clearing pass writes an all-zero (invalid) entry; otherwise write back.
   assign ram_wr_en   = in_clear || (eval_go && verdict.write);
   assign ram_wr_addr = in_clear ? clr_ff : slot;
   assign ram_wr_data = in_clear ? '0 : entry_wr;

   // Negative block indexes report slot zero.
   assign slot_field = blk_ff[31] ? 4'd0 : 4'(slot);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (eval_go) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frt_pkg::FRT_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         blk_ff   <= req_tdata[31:0];
         frag_ff  <= req_tdata[47:32];
         total_ff <= req_tdata[63:48];
         size_ff  <= req_tdata[95:64];
      end
      if (eval_go) begin
         rsp_tdata_ff <= {6'd0, verdict.byte_sum, blk_ff, slot_field};
         rsp_tuser_ff <= verdict.status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `FRT_ASSERT_RST(a_reset_clears, reset |=> (state_ff == frt_pkg::FRT_CLEAR), "reset must start the clearing pass")
   `FRT_ASSERT(a_accept_to_mod, accept |=> (state_ff == frt_pkg::FRT_MOD), "accepted header must enter the remainder step")
   `FRT_ASSERT(a_write_owner, ram_wr_en |-> (state_ff == frt_pkg::FRT_CLEAR || state_ff == frt_pkg::FRT_EVAL), "table write outside clear or write-back")
   `FRT_ASSERT(a_done_frees, (eval_go && verdict.status == frt_pkg::STATUS_DONE) |-> (ram_wr_en && !ram_wr_data[EW-1]), "completed block must free its entry")

endmodule

`default_nettype wire

// ===== dv/frt_status_checker.sv =====
`timescale 1ns / 1ps
// Status checker for the fragment reassembly tracker: predicts one status word
// per accepted header and compares it with the result channel.
// Depends on frt_pkg.

module frt_status_checker #(
   parameter int SLOTS         = 16,
   parameter int MAX_FRAGMENTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [frt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [frt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [frt_pkg::STATUS_W-1:0]    rsp_tuser,
   output int                                   mismatch_count,
   output int                                   status_pending
);

   localparam int SLOT_W    = frt_pkg::SLOT_FIELD_W;
   localparam int BLK_W     = frt_pkg::BLOCK_W;
   localparam int TOT_W     = frt_pkg::TOTAL_W;
   localparam int BLOCK_LSB = SLOT_W;
   localparam int TOTAL_LSB = SLOT_W + BLK_W;

   typedef struct packed {
      frt_pkg::status_type status;
      logic [SLOT_W-1:0]   slot;
      logic [BLK_W-1:0]    block;
      logic [TOT_W-1:0]    total;
   } frag_status_type;

   // Shadow of the reassembly table.
   bit                       slot_open    [SLOTS];
   logic [BLK_W-2:0]         slot_block   [SLOTS];
   logic [MAX_FRAGMENTS-1:0] frag_seen    [SLOTS];
   int unsigned              frags_in     [SLOTS];
   int unsigned              frags_due    [SLOTS];
   logic [TOT_W-1:0]         bytes_so_far [SLOTS];

   frag_status_type status_due [$];

   // Apply one header to the shadow table and return the status it earns.
   function automatic frag_status_type track_fragment(
         input logic [frt_pkg::REQ_TDATA_W-1:0] hdr);
      logic [31:0]        blk;
      logic [15:0]        frag;
      logic [15:0]        cnt;
      logic [31:0]        size;
      logic [TOT_W:0]     sum;
      int unsigned        s;
      frag_status_type    r;
      blk  = hdr[31:0];
      frag = hdr[47:32];
      cnt  = hdr[63:48];
      size = hdr[95:64];
      r.block = blk;
      r.slot  = '0;
      r.total = '0;
      if (blk == frt_pkg::END_MARK) begin
         r.status = frt_pkg::STATUS_END;
         return r;
      end
      if (blk[31]) begin
         r.status = frt_pkg::STATUS_RANGE;
         return r;
      end
      s = blk % SLOTS;
      r.slot = s[SLOT_W-1:0];
      if (slot_open[s] && slot_block[s] != blk[30:0]) begin
         r.status = frt_pkg::STATUS_BUSY;
         return r;
      end
      if (!slot_open[s]) begin
         // first fragment of a block sets the count; a bad one allocates nothing
         if (cnt == 0 || cnt > MAX_FRAGMENTS || frag >= cnt) begin
            r.status = frt_pkg::STATUS_RANGE;
            return r;
         end
         slot_open[s]    = 1'b1;
         slot_block[s]   = blk[30:0];
         frag_seen[s]    = '0;
         frags_in[s]     = 0;
         frags_due[s]    = 32'(cnt);
         bytes_so_far[s] = '0;
      end else if (frag >= frags_due[s]) begin
         r.status = frt_pkg::STATUS_RANGE;
         r.total  = bytes_so_far[s];
         return r;
      end
      if (frag_seen[s][frag]) begin
         r.status = frt_pkg::STATUS_DUP;
         r.total  = bytes_so_far[s];
         return r;
      end
      frag_seen[s][frag] = 1'b1;
      frags_in[s]++;
      sum = {1'b0, bytes_so_far[s]} + (TOT_W + 1)'(size);
      bytes_so_far[s] = (sum > frt_pkg::TOTAL_MAX) ? frt_pkg::TOTAL_MAX : sum[TOT_W-1:0];
      r.total = bytes_so_far[s];
      if (frags_in[s] >= frags_due[s]) begin
         slot_open[s] = 1'b0;
         r.status = frt_pkg::STATUS_DONE;
      end else begin
         r.status = frt_pkg::STATUS_STORED;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      frag_status_type want;
      bit              bad;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_open[i] = 1'b0;
         status_due.delete();
      end else begin
         if (req_tvalid && req_tready) status_due.push_back(track_fragment(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               $error("status word with none expected: status %0d, done_block %0d",
                      rsp_tuser, $signed(rsp_tdata[BLOCK_LSB +: BLK_W]));
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = status_due.pop_front();
               bad  = 1'b0;
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  bad = 1'b1;
               end
               if (rsp_tdata[SLOT_W-1:0] !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[SLOT_W-1:0]);
                  bad = 1'b1;
               end
               if (rsp_tdata[BLOCK_LSB +: BLK_W] !== want.block) begin
                  $error("done_block: expected %0d, got %0d", $signed(want.block),
                         $signed(rsp_tdata[BLOCK_LSB +: BLK_W]));
                  bad = 1'b1;
               end
               if (rsp_tdata[TOTAL_LSB +: TOT_W] !== want.total) begin
                  $error("byte_sum: expected %0d, got %0d", want.total,
                         rsp_tdata[TOTAL_LSB +: TOT_W]);
                  bad = 1'b1;
               end
               if (bad) mismatch_count <= mismatch_count + 1;
            end
         end
      end
      status_pending <= status_due.size();
   end

endmodule

// ===== dv/tb_fragment_reassembly_tracker_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the fragment reassembly tracker: drives fragment headers and
// result back-pressure, gives the verdict. Depends on frt_pkg and frt_status_checker.

module tb_fragment_reassembly_tracker_top;

   localparam int SLOT_COUNT  = 16;
   localparam int MAX_FRAGS   = 64;
   localparam int ITEM_TARGET = 1850;
   localparam int QUIET_TAIL  = 300;   // last headers go out with no idling
   localparam int TIMEOUT_NS  = 1_000_000;

   typedef enum int {
      NOISE_END,
      NOISE_NEGATIVE,
      NOISE_BAD_COUNT,
      NOISE_FRAG_PAST_COUNT,
      NOISE_OPEN_PAST_COUNT
   } noise_kind_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // req_tdata, low bit up: blk_id, frag_pos, frag_total, payload_bytes
   logic [frt_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // rsp_tdata, low bit up: slot, done_block, byte_sum, zero pad
   logic [frt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   // rsp_tuser: status
   logic [frt_pkg::STATUS_W-1:0]    rsp_tuser;

   int mismatch_count;
   int status_pending;

   int headers_sent;
   bit quiet;        // no idling on either side once set
   bit gap_mode;     // sender inserts gaps while set
   bit stall_mode;   // receiver stalls while set

   // Blocks the tracker still holds open, per slot, so later runs can finish them.
   bit          own_open  [SLOT_COUNT];
   logic [31:0] own_block [SLOT_COUNT];
   int unsigned own_count [SLOT_COUNT];

   fragment_reassembly_tracker_top #(
      .SLOTS(SLOT_COUNT),
      .MAX_FRAGMENTS(MAX_FRAGS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   frt_status_checker #(
      .SLOTS(SLOT_COUNT),
      .MAX_FRAGMENTS(MAX_FRAGS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count),
      .status_pending(status_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Present one header word from a falling edge and hold it until accepted.
   // Call at a falling edge; returns at the falling edge after the handshake.
   task automatic send_header(input logic [31:0] blk, input logic [15:0] frag,
                              input logic [15:0] cnt, input logic [31:0] size);
      if (headers_sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && gap_mode && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {size, cnt, frag, blk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      headers_sent++;
      if ($urandom_range(0, 59) == 0) gap_mode = !gap_mode;
   endtask

   // Drop valid and hold off until every status word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (status_pending != 0);
   endtask

   // One header the tracker must reject or flag; none of these allocates an entry.
   task automatic send_noise();
      noise_kind_type kind;
      int unsigned    s;
      logic [31:0]    blk;
      logic [15:0]    cnt;
      kind = noise_kind_type'($urandom_range(0, 4));
      blk  = $urandom & 32'h7FFF_FFFF;
      case (kind)
         NOISE_END: begin
            send_header(frt_pkg::END_MARK, 16'($urandom), 16'($urandom), $urandom);
         end
         NOISE_NEGATIVE: begin
            send_header($urandom | 32'h8000_0000, 16'($urandom), 16'($urandom), $urandom);
         end
         NOISE_BAD_COUNT: begin
            cnt = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(MAX_FRAGS + 1, 16'hFFFF));
            send_header(blk, 16'($urandom), cnt, $urandom);
         end
         NOISE_FRAG_PAST_COUNT: begin
            cnt = 16'($urandom_range(1, MAX_FRAGS));
            send_header(blk, 16'($urandom_range(cnt, 16'hFFFF)), cnt, $urandom);
         end
         default: begin
            // past the count of a block that is still open, else a zero count
            s = $urandom_range(0, SLOT_COUNT - 1);
            if (own_open[s])
               send_header(own_block[s], 16'($urandom_range(own_count[s], 16'hFFFF)),
                           16'($urandom), $urandom);
            else
               send_header((blk & 32'h7FFF_FFF0) | s, 16'($urandom_range(0, 15)), 16'd0,
                           $urandom);
         end
      endcase
   endtask

   // Send up to four blocks on distinct slots, fragments shuffled together, with
   // repeats; now and then leave one fragment out so the block stays open.
   task automatic run_episode();
      int unsigned k, n_items, i, j, s, pick, tmp_o;
      logic [15:0] used;
      logic [31:0] blk [4];
      int unsigned frags [4];
      int unsigned slot_of [4];
      int unsigned drop [4];
      bit          fresh [4];
      bit          broken [4];
      bit          max_bytes [4];
      bit          seen [4];
      int unsigned item_owner [512];
      logic [15:0] item_frag [512];
      logic [15:0] tmp_f;
      logic [15:0] cnt;
      logic [31:0] size;
      k       = $urandom_range(1, 4);
      used    = '0;
      n_items = 0;
      for (j = 0; j < k; j++) begin
         do s = $urandom_range(0, SLOT_COUNT - 1); while (used[s]);
         used[s]    = 1'b1;
         slot_of[j] = s;
         if (own_open[s]) begin
            blk[j]   = own_block[s];
            frags[j] = own_count[s];
            fresh[j] = 1'b0;
         end else begin
            fresh[j] = 1'b1;
            if ($urandom_range(0, 1))
               blk[j] = ($urandom & 32'h7FFF_FFF0) | s;
            else
               blk[j] = s + SLOT_COUNT * $urandom_range(0, 3);
            // mostly short blocks, a few long ones, the full count now and then
            pick = $urandom_range(0, 19);
            if (pick < 16)
               frags[j] = $urandom_range(1, 6);
            else if (pick < 19)
               frags[j] = $urandom_range(7, 20);
            else
               frags[j] = $urandom_range(0, 1) ? MAX_FRAGS : $urandom_range(21, MAX_FRAGS - 1);
         end
         broken[j]    = fresh[j] && frags[j] > 1 && $urandom_range(0, 9) == 0;
         drop[j]      = $urandom_range(0, frags[j] - 1);
         max_bytes[j] = ($urandom_range(0, 9) == 0);
         seen[j]      = 1'b0;
         for (i = 0; i < frags[j]; i++) begin
            if (!(broken[j] && i == drop[j])) begin
               item_owner[n_items] = j;
               item_frag[n_items]  = 16'(i);
               n_items++;
               if ($urandom_range(0, 6) == 0) begin
                  item_owner[n_items] = j;
                  item_frag[n_items]  = 16'(i);
                  n_items++;
               end
            end
         end
      end
      for (i = n_items; i > 1; i--) begin
         pick               = $urandom_range(0, i - 1);
         tmp_o              = item_owner[i-1];
         tmp_f              = item_frag[i-1];
         item_owner[i-1]    = item_owner[pick];
         item_frag[i-1]     = item_frag[pick];
         item_owner[pick]   = tmp_o;
         item_frag[pick]    = tmp_f;
      end
      for (i = 0; i < n_items; i++) begin
         j = item_owner[i];
         // first header of a new block carries the real count; later ones may lie
         if (fresh[j] && !seen[j])
            cnt = 16'(frags[j]);
         else if ($urandom_range(0, 4) == 0)
            cnt = 16'($urandom);
         else
            cnt = 16'(frags[j]);
         seen[j] = 1'b1;
         if (max_bytes[j])
            size = '1;
         else if ($urandom_range(0, 1))
            size = $urandom;
         else
            size = $urandom_range(0, 1500);
         send_header(blk[j], item_frag[i], cnt, size);
      end
      // A repeat landing after completion reopens its block; carry over whatever
      // the tracker still holds open so the next run can finish it.
      for (j = 0; j < k; j++) begin
         s = slot_of[j];
         own_open[s] = u_checker.slot_open[s];
         if (own_open[s]) begin
            own_block[s] = {1'b0, u_checker.slot_block[s]};
            own_count[s] = u_checker.frags_due[s];
         end
      end
   endtask

   // Receiver: stall in bursts while stall_mode is set, never once quiet.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
         if (!quiet && stall_mode && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      headers_sent = 0;
      quiet        = 1'b0;
      gap_mode     = 1'b1;
      stall_mode   = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) own_open[i] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: markers, bad counts, the whole life of a few blocks.
      send_header(frt_pkg::END_MARK, 16'd0, 16'd1, 32'd0);        // end marker
      send_header(32'h8000_0000, 16'd0, 16'd1, 32'd5);           // other negative index
      send_header(32'd3, 16'd0, 16'd0, 32'd10);                  // zero count
      send_header(32'd3, 16'd0, 16'd65, 32'd10);                 // count above the limit
      send_header(32'd3, 16'hFFFF, 16'hFFFF, 32'd10);            // both counts at the top
      send_header(32'd3, 16'd2, 16'd2, 32'd10);                  // new block, index past count
      send_header(32'h7FFF_FFFF, 16'd0, 16'd1, 32'hFFFF_FFFF);   // one-fragment block
      send_header(32'd5, 16'd1, 16'd3, 32'd100);                 // open block 5
      send_header(32'd5, 16'd1, 16'd3, 32'd7);                   // repeat fragment
      send_header(32'd21, 16'd0, 16'd2, 32'd9);                  // slot taken by block 5
      send_header(32'd5, 16'd3, 16'd3, 32'd1);                   // open block, index past count
      send_header(32'd5, 16'd0, 16'd64, 32'd0);                  // later count is ignored
      send_header(32'd5, 16'd2, 16'd1, 32'hFFFF_FFFF);           // completes block 5
      send_header(32'd21, 16'd0, 16'd2, 32'd0);                  // slot free again
      send_header(32'd21, 16'd1, 16'd2, 32'd1);
      send_header(32'd64, 16'd63, 16'd64, 32'hFFFF_FFFF);        // full count, last index
      own_open[0]  = 1'b1;
      own_block[0] = 32'd64;
      own_count[0] = MAX_FRAGS;
      send_header(32'd16, 16'd0, 16'd1, 32'hFFFF_FFFF);          // collides with block 64
      send_header(frt_pkg::END_MARK, 16'd5, 16'd5, 32'd5);       // marker with state held
      drain_results();

      // Random: mostly whole blocks, some broken ones, some rejected headers.
      while (headers_sent < ITEM_TARGET) begin
         if (headers_sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 49) == 0) drain_results();
         if ($urandom_range(0, 3) != 0)
            run_episode();
         else
            repeat ($urandom_range(1, 6)) send_noise();
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && status_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/frt_pkg.sv
sv/frt_ram.sv
sv/frt_slot_map.sv
sv/frt_update.sv
sv/fragment_reassembly_tracker_top.sv
dv/frt_status_checker.sv
dv/tb_fragment_reassembly_tracker_top.sv
